// File: rtl/core/wmcmd_pkg.sv
`default_nettype none

package wmcmd_pkg;

  // Grid and window limits.
  localparam int MAX_ROWS   = 128;
  localparam int MAX_COLS   = 128;
  localparam int MAX_RADIUS = 7;

  localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int CELLS   = MAX_ROWS * MAX_COLS;

  // Index into one line of the grid, a count that can hold the line length,
  // and a compare width wide enough for both the count and an 8-bit size register.
  localparam int POS_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  // Window tap position: line index plus tap offset, with a sign bit.
  localparam int TAP_W = POS_W + 6;

  // Datapath widths: Q0.15 cells, Q1.15 weights.
  localparam int VAL_W  = 15;
  localparam int WGT_W  = 16;
  localparam int PROD_W = VAL_W + WGT_W;

  localparam logic [VAL_W-1:0] COST_MAX     = 15'd32767;
  localparam logic [VAL_W-1:0] UNKNOWN_COST = 15'd9830;

  // Operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Result kinds.
  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_LO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_HI    = 3'd4;

  typedef struct packed {
    logic [1:0]         operation;
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [15:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [VAL_W-1:0] cost_value;
    logic             out_of_map;
  } out_item_t;

  // Row-major cell address.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] r,
                                                  input logic [POS_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/wmcmd_ram.sv
`default_nettype none

module wmcmd_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/weighted_max_cost_map_dilation_unit.sv
`default_nettype none

// Occupancy grid to cost map dilation. A write transaction stores one grid cell (unknown,
// i.e. negative, cells are stored as 0.3) and gives no result. A read transaction returns
// one cost cell in the cycle after acceptance, or maximum cost with out_of_map set for an
// index outside the configured map. A build transaction runs a row pass and then a column
// pass of a weighted maximum over +-window_radius neighbours and returns one result when
// done. The single multiply/compare unit takes one window tap a cycle from one memory read
// port; each output cell then drains through the DRAIN1, DRAIN2 and STORE states. No
// transaction is accepted during a build. The grid memories are not cleared after reset:
// cells must be written before they are built over, and a map must be built before it is
// read.
module weighted_max_cost_map_dilation_unit import wmcmd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_item,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_STORE
  } state_t;

  state_t state;

  // Configuration.
  logic [7:0]  map_rows;
  logic [7:0]  map_cols;
  logic [2:0]  window_radius;
  logic [63:0] kernel_weights_lo;
  logic [63:0] kernel_weights_hi;

  // Sequencer.
  logic             col_pass;
  logic [POS_W-1:0] line;
  logic [POS_W-1:0] pos;
  logic [3:0]       k;

  // Multiply/compare pipeline.
  logic             s1_valid;
  logic [WGT_W-1:0] s1_weight;
  logic             s2_valid;
  logic [PROD_W-1:0] s2_prod;
  logic [VAL_W-1:0] acc;

  // Output register.
  logic out_kind;
  logic out_oob;

  // Combinational signals.
  logic [1:0]        op;
  logic              in_acc;
  logic              slot_free;
  logic              result_now;
  logic [CNT_W-1:0]  eff_rows;
  logic [CNT_W-1:0]  eff_cols;
  logic [2:0]        eff_r;
  logic [3:0]        two_r;
  logic [CNT_W-1:0]  line_len;
  logic [CNT_W-1:0]  line_cnt;
  logic [TAP_W-1:0]  n;
  logic              tap_ok;
  logic              tap_rd;
  logic [POS_W-1:0]  npos;
  logic [3:0]        tap_dist;
  logic [127:0]      weights;
  logic [WGT_W-1:0]  weight;
  logic              in_map;
  logic [ADDR_W-1:0] in_addr;
  logic [ADDR_W-1:0] tap_addr;
  logic [ADDR_W-1:0] store_addr;
  logic [VAL_W-1:0]  raw_wdata;
  logic [VAL_W-1:0]  raw_q;
  logic [VAL_W-1:0]  rp_q;
  logic [VAL_W-1:0]  cost_q;
  logic [VAL_W-1:0]  tap_q;
  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  sat;

  always_comb begin
    op        = in_item.operation;
    slot_free = !out_valid || out_ready;
    // Writes and unused codes give no result, so they need no free output slot.
    in_ready  = (state == ST_IDLE) && (slot_free || !(op inside {OP_BUILD, OP_READ}));
    in_acc    = in_valid && in_ready;

    eff_rows = (CMP_W'(map_rows) > CMP_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : CNT_W'(map_rows);
    eff_cols = (CMP_W'(map_cols) > CMP_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : CNT_W'(map_cols);
    eff_r    = (window_radius > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : window_radius;
    two_r    = {eff_r, 1'b0};

    // A transaction that loads the output register at this edge.
    result_now = in_acc && ((op == OP_READ) ||
                 ((op == OP_BUILD) && ((eff_rows == '0) || (eff_cols == '0))));

    line_len = col_pass ? eff_rows : eff_cols;
    line_cnt = col_pass ? eff_cols : eff_rows;

    // Neighbour position along the line; taps beyond either end are skipped.
    n      = TAP_W'(pos) + TAP_W'(k) - TAP_W'(eff_r);
    tap_ok = !n[TAP_W-1] && (n[TAP_W-2:0] < (TAP_W-1)'(line_len));
    tap_rd = (state == ST_TAP) && tap_ok;
    npos   = n[POS_W-1:0];

    tap_dist = (k > {1'b0, eff_r}) ? (k - {1'b0, eff_r}) : ({1'b0, eff_r} - k);
    weights  = {kernel_weights_hi, kernel_weights_lo};
    weight   = weights[{tap_dist[2:0], 4'b0000} +: WGT_W];

    in_map  = (CMP_W'(in_item.row) < CMP_W'(eff_rows)) &&
              (CMP_W'(in_item.col) < CMP_W'(eff_cols));
    in_addr = cell_addr(POS_W'(in_item.row), POS_W'(in_item.col));

    tap_addr   = col_pass ? cell_addr(npos, line) : cell_addr(line, npos);
    store_addr = col_pass ? cell_addr(pos, line)  : cell_addr(line, pos);

    raw_wdata = in_item.cell_value[15] ? UNKNOWN_COST : in_item.cell_value[VAL_W-1:0];

    tap_q = col_pass ? rp_q : raw_q;
    prod  = PROD_W'(tap_q) * PROD_W'(s1_weight);
    // The product is shifted right by 15; anything at or above 1.0 saturates.
    sat   = s2_prod[PROD_W-1] ? COST_MAX : s2_prod[PROD_W-2:WGT_W-1];

    out_item.result_kind = out_kind;
    out_item.out_of_map  = out_oob;
    out_item.cost_value  = (out_kind == KIND_READ) ? (out_oob ? COST_MAX : cost_q) : '0;
  end

  wmcmd_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_raw_grid (
    .clk     (clk),
    .wr_en   (in_acc && (op == OP_WRITE) && in_map),
    .wr_addr (in_addr),
    .wr_data (raw_wdata),
    .rd_en   (tap_rd && !col_pass),
    .rd_addr (tap_addr),
    .rd_data (raw_q)
  );

  wmcmd_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_row_pass_store (
    .clk     (clk),
    .wr_en   ((state == ST_STORE) && !col_pass),
    .wr_addr (store_addr),
    .wr_data (acc),
    .rd_en   (tap_rd && col_pass),
    .rd_addr (tap_addr),
    .rd_data (rp_q)
  );

  wmcmd_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_cost_store (
    .clk     (clk),
    .wr_en   ((state == ST_STORE) && col_pass),
    .wr_addr (store_addr),
    .wr_data (acc),
    .rd_en   (in_acc && (op == OP_READ)),
    .rd_addr (in_addr),
    .rd_data (cost_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      out_valid         <= 1'b0;
      s1_valid          <= 1'b0;
      s2_valid          <= 1'b0;
      map_rows          <= 8'd128;
      map_cols          <= 8'd128;
      window_radius     <= 3'd3;
      kernel_weights_lo <= '0;
      kernel_weights_hi <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_MAP_ROWS:      map_rows          <= cfg_data[7:0];
          CFG_MAP_COLS:      map_cols          <= cfg_data[7:0];
          CFG_WINDOW_RADIUS: window_radius     <= cfg_data[2:0];
          CFG_WEIGHTS_LO:    kernel_weights_lo <= cfg_data;
          CFG_WEIGHTS_HI:    kernel_weights_hi <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready && !result_now) begin
        out_valid <= 1'b0;
      end

      s1_valid  <= tap_rd;
      s1_weight <= weight;
      s2_valid  <= s1_valid;
      s2_prod   <= prod;
      if (s2_valid && (sat > acc)) begin
        acc <= sat;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (op == OP_READ) begin
              out_valid <= 1'b1;
              out_kind  <= KIND_READ;
              out_oob   <= !in_map;
            end else if (op == OP_BUILD) begin
              if ((eff_rows == '0) || (eff_cols == '0)) begin
                out_valid <= 1'b1;
                out_kind  <= KIND_BUILD;
                out_oob   <= 1'b0;
              end else begin
                state    <= ST_TAP;
                col_pass <= 1'b0;
                line     <= '0;
                pos      <= '0;
                k        <= '0;
                acc      <= '0;
              end
            end
          end
        end
        ST_TAP: begin
          if (k == two_r) begin
            state <= ST_DRAIN1;
          end else begin
            k <= k + 4'd1;
          end
        end
        ST_DRAIN1: state <= ST_DRAIN2;
        ST_DRAIN2: state <= ST_STORE;
        ST_STORE: begin
          acc <= '0;
          k   <= '0;
          if ((CNT_W'(pos) + CNT_W'(1)) < line_len) begin
            pos   <= pos + POS_W'(1);
            state <= ST_TAP;
          end else if ((CNT_W'(line) + CNT_W'(1)) < line_cnt) begin
            line  <= line + POS_W'(1);
            pos   <= '0;
            state <= ST_TAP;
          end else if (!col_pass) begin
            col_pass <= 1'b1;
            line     <= '0;
            pos      <= '0;
            state    <= ST_TAP;
          end else begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
            out_kind  <= KIND_BUILD;
            out_oob   <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // No result may be presented and no transaction accepted while a build is still running.
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (!out_valid && !in_ready))
    else $error("result or acceptance during a build");

  // The pipeline must be empty when the accumulated maximum is stored.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_STORE) |-> (!s1_valid && !s2_valid))
    else $error("cell stored before the multiply pipeline drained");

  // After a store the sequencer either starts the next cell or finishes.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_STORE) |=> ((state == ST_TAP) || (state == ST_IDLE)))
    else $error("unexpected state after a store");

  // A build answer carries no cost and no map flag.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.result_kind == KIND_BUILD)) |->
      ((out_item.cost_value == '0) && !out_item.out_of_map))
    else $error("build answer with a non-zero payload");

endmodule

`default_nettype wire
